/* hw/rtl/dmpd_pkg.sv */
// Package for the dual motor PWM drive unit.
// Holds command, direction and register index codes and the H-bridge pin patterns.
// No dependencies.
`timescale 1ns / 1ps

package dmpd_pkg;

   localparam int unsigned CmdWidth    = 3;
   localparam int unsigned DirWidth    = 3;
   localparam int unsigned CountWidth  = 32;
   localparam int unsigned DutyWidth   = 8;
   localparam int unsigned LimitWidth  = 16;
   localparam int unsigned CsrIdxWidth = 2;
   localparam int unsigned CsrWidth    = 16;

   // A tick that finds the PWM counter at this value treats it as zero.
   localparam logic [DutyWidth-1:0] PwmWrap = 8'd255;

   typedef enum logic [CmdWidth-1:0] {
      CMD_TICK      = 3'd0,
      CMD_LEFT_PULSE  = 3'd1,
      CMD_RIGHT_PULSE = 3'd2,
      CMD_SET_DIR   = 3'd3,
      CMD_START     = 3'd4,
      CMD_BRAKE     = 3'd5
   } cmd_type;

   typedef enum logic [DirWidth-1:0] {
      DIR_FORWARD     = 3'd0,
      DIR_BACKWARD    = 3'd1,
      DIR_LEFT        = 3'd2,
      DIR_RIGHT       = 3'd3,
      DIR_SHORT_BRAKE = 3'd4,
      DIR_COAST       = 3'd5
   } dir_type;

   typedef enum logic [CsrIdxWidth-1:0] {
      CSR_LOW_SPEED  = 2'd0,
      CSR_MED_SPEED  = 2'd1,
      CSR_DIFF_LIMIT = 2'd2
   } csr_idx_type;

   // Bridge pin order: bit 0 left_in_a, 1 left_in_b, 2 right_in_a, 3 right_in_b.
   typedef logic [3:0] bridge_type;

   localparam bridge_type BridgeForward  = 4'b1010;
   localparam bridge_type BridgeBackward = 4'b0101;
   localparam bridge_type BridgeLeft     = 4'b0110;
   localparam bridge_type BridgeRight    = 4'b1001;
   localparam bridge_type BridgeShort    = 4'b1111;
   localparam bridge_type BridgeCoast    = 4'b0000;

   localparam logic [DutyWidth-1:0]  LowSpeedReset  = 8'd100;
   localparam logic [DutyWidth-1:0]  MedSpeedReset  = 8'd180;
   localparam logic [LimitWidth-1:0] DiffLimitReset = 16'd10;

   function automatic bridge_type decode_dir(input logic [DirWidth-1:0] dir);
      bridge_type pins;
      case (dir)
         DIR_FORWARD:     pins = BridgeForward;
         DIR_BACKWARD:    pins = BridgeBackward;
         DIR_LEFT:        pins = BridgeLeft;
         DIR_RIGHT:       pins = BridgeRight;
         DIR_SHORT_BRAKE: pins = BridgeShort;
         default:         pins = BridgeCoast;
      endcase
      return pins;
   endfunction

endpackage

/* hw/rtl/dual_motor_pwm_drive_unit.sv */
// Top level of the dual motor PWM drive unit.
// Depends on dmpd_pkg for codes, pin patterns and register reset values.
`timescale 1ns / 1ps

// The unit takes one command per cycle while the result side keeps up and returns
// exactly one result per command, in order. A command is first captured in an
// input register; once the result register is free or being emptied, a single
// pass of logic applies it to the drive state (PWM counter, encoder counts,
// revolution goal, duties, bridge pins and the brake hold) and loads the result
// register. The sustained rate is one command per cycle when the result side does
// not stall, limited by the single state update per cycle.
// At most two commands are held, one in the input register and one in the result
// register. req_ready follows rsp_ready in the same cycle, so once both registers
// are occupied and the result side stalls, req_ready drops in that same cycle.
// Configuration writes through the csr_ port take effect at the next edge
// and should only be issued while no command is in flight.
module dual_motor_pwm_drive_unit
   import dmpd_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   // Command channel.
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [CmdWidth-1:0]    req_command,
   input  logic [DirWidth-1:0]    req_direction,
   input  logic [CountWidth-1:0]  req_target_revs,
   // Result channel.
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic                   rsp_left_pwm,
   output logic                   rsp_right_pwm,
   output logic                   rsp_left_in_a,
   output logic                   rsp_left_in_b,
   output logic                   rsp_right_in_a,
   output logic                   rsp_right_in_b,
   output logic                   rsp_target_reached,
   // Configuration write port.
   input  logic                   csr_write_en,
   input  logic [CsrIdxWidth-1:0] csr_index,
   input  logic [CsrWidth-1:0]    csr_wdata
);

   // Configuration registers.
   logic [DutyWidth-1:0]  low_speed_ff;
   logic [DutyWidth-1:0]  med_speed_ff;
   logic [LimitWidth-1:0] diff_limit_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         low_speed_ff  <= LowSpeedReset;
         med_speed_ff  <= MedSpeedReset;
         diff_limit_ff <= DiffLimitReset;
      end else if (csr_write_en) begin
         case (csr_index)
            CSR_LOW_SPEED:  low_speed_ff  <= csr_wdata[DutyWidth-1:0];
            CSR_MED_SPEED:  med_speed_ff  <= csr_wdata[DutyWidth-1:0];
            CSR_DIFF_LIMIT: diff_limit_ff <= csr_wdata;
            default:        ;
         endcase
      end
   end

   // Input register stage.
   logic                  s1_valid_ff;
   logic [CmdWidth-1:0]   s1_command_ff;
   logic [DirWidth-1:0]   s1_direction_ff;
   logic [CountWidth-1:0] s1_target_ff;

   // The command in the input register is applied when the result register is
   // free or its contents are being transferred out in this cycle.
   logic s1_fire;
   logic req_fire;

   assign s1_fire   = s1_valid_ff && (!rsp_valid || rsp_ready);
   assign req_ready = !s1_valid_ff || s1_fire;
   assign req_fire  = req_valid && req_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_ready) begin
         s1_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_command_ff   <= req_command;
         s1_direction_ff <= req_direction;
         s1_target_ff    <= req_target_revs;
      end
   end

   // Drive state.
   logic [DutyWidth-1:0]  pwm_counter_ff, pwm_counter_in;
   logic [CountWidth-1:0] left_count_ff, left_count_in;
   logic [CountWidth-1:0] right_count_ff, right_count_in;
   logic [CountWidth-1:0] revs_goal_ff, revs_goal_in;
   logic [DutyWidth-1:0]  left_duty_ff, left_duty_in;
   logic [DutyWidth-1:0]  right_duty_ff, right_duty_in;
   bridge_type            bridge_pins_ff, bridge_pins_in;
   logic                  brake_hold_ff, brake_hold_in;
   logic                  pin_left_ff, pin_left_in;
   logic                  pin_right_ff, pin_right_in;

   // Balance decision from the signed encoder difference. The difference is
   // sign-extended by one bit so it compares cleanly against plus and minus limit.
   logic [CountWidth-1:0]      count_diff;
   logic signed [CountWidth:0] diff_ext;
   logic signed [CountWidth:0] limit_pos;
   logic signed [CountWidth:0] limit_neg;
   logic                       left_ahead;
   logic                       right_ahead;
   logic [DutyWidth-1:0]       bal_left_duty;
   logic [DutyWidth-1:0]       bal_right_duty;
   logic [DutyWidth-1:0]       pwm_eff;

   assign count_diff = left_count_ff - right_count_ff;
   assign diff_ext   = $signed({count_diff[CountWidth-1], count_diff});
   assign limit_pos  = $signed({{(CountWidth + 1 - LimitWidth){1'b0}}, diff_limit_ff});
   assign limit_neg  = -limit_pos;
   assign left_ahead  = diff_ext > limit_pos;
   assign right_ahead = diff_ext < limit_neg;

   always_comb begin
      if (left_ahead) begin
         bal_left_duty  = low_speed_ff;
         bal_right_duty = med_speed_ff;
      end else if (right_ahead) begin
         bal_left_duty  = med_speed_ff;
         bal_right_duty = low_speed_ff;
      end else begin
         bal_left_duty  = med_speed_ff;
         bal_right_duty = med_speed_ff;
      end
   end

   // A tick that finds the counter at the wrap value compares against zero.
   assign pwm_eff = (pwm_counter_ff == PwmWrap) ? '0 : pwm_counter_ff;

   always_comb begin
      pwm_counter_in = pwm_counter_ff;
      left_count_in  = left_count_ff;
      right_count_in = right_count_ff;
      revs_goal_in   = revs_goal_ff;
      left_duty_in   = left_duty_ff;
      right_duty_in  = right_duty_ff;
      bridge_pins_in = bridge_pins_ff;
      brake_hold_in  = brake_hold_ff;
      pin_left_in    = pin_left_ff;
      pin_right_in   = pin_right_ff;
      case (s1_command_ff)
         CMD_TICK: begin
            if (!brake_hold_ff) begin
               left_duty_in  = bal_left_duty;
               right_duty_in = bal_right_duty;
            end
            pin_left_in    = pwm_eff <= left_duty_in;
            pin_right_in   = pwm_eff <= right_duty_in;
            pwm_counter_in = pwm_eff + 8'd1;
         end
         CMD_LEFT_PULSE: begin
            left_count_in = left_count_ff + 32'd1;
         end
         CMD_RIGHT_PULSE: begin
            right_count_in = right_count_ff + 32'd1;
         end
         CMD_SET_DIR: begin
            bridge_pins_in = decode_dir(s1_direction_ff);
            brake_hold_in  = 1'b0;
         end
         CMD_START: begin
            left_count_in  = '0;
            right_count_in = '0;
            revs_goal_in   = s1_target_ff;
         end
         CMD_BRAKE: begin
            bridge_pins_in = BridgeCoast;
            left_duty_in   = '0;
            right_duty_in  = '0;
            brake_hold_in  = 1'b1;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pwm_counter_ff <= '0;
         left_count_ff  <= '0;
         right_count_ff <= '0;
         revs_goal_ff   <= '0;
         left_duty_ff   <= '0;
         right_duty_ff  <= '0;
         bridge_pins_ff <= BridgeCoast;
         brake_hold_ff  <= 1'b0;
         pin_left_ff    <= 1'b0;
         pin_right_ff   <= 1'b0;
      end else if (s1_fire) begin
         pwm_counter_ff <= pwm_counter_in;
         left_count_ff  <= left_count_in;
         right_count_ff <= right_count_in;
         revs_goal_ff   <= revs_goal_in;
         left_duty_ff   <= left_duty_in;
         right_duty_ff  <= right_duty_in;
         bridge_pins_ff <= bridge_pins_in;
         brake_hold_ff  <= brake_hold_in;
         pin_left_ff    <= pin_left_in;
         pin_right_ff   <= pin_right_in;
      end
   end

   // Result register.
   logic       rsp_valid_ff;
   logic       rsp_left_pwm_ff;
   logic       rsp_right_pwm_ff;
   bridge_type rsp_bridge_ff;
   logic       rsp_reached_ff;
   logic       reached_in;

   assign reached_in = (left_count_in >= revs_goal_in) || (right_count_in >= revs_goal_in);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s1_fire) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_fire) begin
         rsp_left_pwm_ff  <= pin_left_in;
         rsp_right_pwm_ff <= pin_right_in;
         rsp_bridge_ff    <= bridge_pins_in;
         rsp_reached_ff   <= reached_in;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_left_pwm       = rsp_left_pwm_ff;
   assign rsp_right_pwm      = rsp_right_pwm_ff;
   assign rsp_left_in_a      = rsp_bridge_ff[0];
   assign rsp_left_in_b      = rsp_bridge_ff[1];
   assign rsp_right_in_a     = rsp_bridge_ff[2];
   assign rsp_right_in_b     = rsp_bridge_ff[3];
   assign rsp_target_reached = rsp_reached_ff;

   // While the brake hold is set both duties stay at zero.
   assert property (@(posedge clock) disable iff (reset)
      brake_hold_ff |-> (left_duty_ff == '0) && (right_duty_ff == '0))
      else $error("duty nonzero during brake hold");

   // While the brake hold is set the bridge stays in coast.
   assert property (@(posedge clock) disable iff (reset)
      brake_hold_ff |-> (bridge_pins_ff == BridgeCoast))
      else $error("bridge not coasting during brake hold");

   // A captured command is never dropped while the result side stalls.
   assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && rsp_valid && !rsp_ready) |=> s1_valid_ff && rsp_valid)
      else $error("command lost under result backpressure");

endmodule

/* sim/dual_motor_pwm_drive_unit_tb.sv */
// Self-checking testbench for the dual motor PWM drive unit.
// Drives commands with random stalls on both handshakes and checks every result
// against an in-bench model of the drive state. Depends on dmpd_pkg and the RTL top.
`timescale 1ns / 1ps

module dual_motor_pwm_drive_unit_tb;
   import dmpd_pkg::*;

   localparam int unsigned ClockPeriod = 10;
   // A correct run ends well inside this limit, even with the slowest idling mix.
   localparam int unsigned CycleLimit  = 300000;
   localparam int unsigned MaxReported = 10;
   // A tick that finds the PWM counter here restarts it from zero.
   localparam logic [DutyWidth-1:0] PwmTop = 8'd255;

   // One result as seen on the pins, in port order.
   typedef struct packed {
      logic left_pwm;
      logic right_pwm;
      logic left_in_a;
      logic left_in_b;
      logic right_in_a;
      logic right_in_b;
      logic target_reached;
   } pin_state_type;

   logic                   clock;
   logic                   reset           = 1'b1;
   logic                   req_valid       = 1'b0;
   logic                   req_ready;
   logic [CmdWidth-1:0]    req_command     = '0;
   logic [DirWidth-1:0]    req_direction   = '0;
   logic [CountWidth-1:0]  req_target_revs = '0;
   logic                   rsp_valid;
   logic                   rsp_ready       = 1'b0;
   logic                   rsp_left_pwm;
   logic                   rsp_right_pwm;
   logic                   rsp_left_in_a;
   logic                   rsp_left_in_b;
   logic                   rsp_right_in_a;
   logic                   rsp_right_in_b;
   logic                   rsp_target_reached;
   logic                   csr_write_en    = 1'b0;
   logic [CsrIdxWidth-1:0] csr_index       = CSR_LOW_SPEED;
   logic [CsrWidth-1:0]    csr_wdata       = '0;

   dual_motor_pwm_drive_unit i_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_command        (req_command),
      .req_direction      (req_direction),
      .req_target_revs    (req_target_revs),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_left_pwm       (rsp_left_pwm),
      .rsp_right_pwm      (rsp_right_pwm),
      .rsp_left_in_a      (rsp_left_in_a),
      .rsp_left_in_b      (rsp_left_in_b),
      .rsp_right_in_a     (rsp_right_in_a),
      .rsp_right_in_b     (rsp_right_in_b),
      .rsp_target_reached (rsp_target_reached),
      .csr_write_en       (csr_write_en),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata)
   );

   // Shared run state. The idle percentages are set by the main sequence and
   // read by the sender task and by the result process.
   int unsigned   sender_idle_pct   = 0;
   int unsigned   receiver_idle_pct = 0;
   int unsigned   hold_request      = 0;
   int unsigned   items_sent        = 0;
   int unsigned   error_count       = 0;
   int unsigned   cycle_count       = 0;
   pin_state_type expected_pins[$];

   // Drive state as the block should hold it. Registers keep the block's widths
   // so that counter and encoder wrap come out of the arithmetic by themselves.
   logic [DutyWidth-1:0]  pwm_phase;
   logic [CountWidth-1:0] left_revs;
   logic [CountWidth-1:0] right_revs;
   logic [CountWidth-1:0] goal_revs;
   logic [DutyWidth-1:0]  duty_left;
   logic [DutyWidth-1:0]  duty_right;
   bridge_type            bridge_now;
   logic                  brake_latched;
   logic                  enable_left;
   logic                  enable_right;
   logic [DutyWidth-1:0]  low_duty_cfg;
   logic [DutyWidth-1:0]  med_duty_cfg;
   logic [LimitWidth-1:0] skew_limit_cfg;

   function automatic void reset_drive_state();
      pwm_phase      = '0;
      left_revs      = '0;
      right_revs     = '0;
      goal_revs      = '0;
      duty_left      = '0;
      duty_right     = '0;
      bridge_now     = 4'b0000;
      brake_latched  = 1'b0;
      enable_left    = 1'b0;
      enable_right   = 1'b0;
      low_duty_cfg   = LowSpeedReset;
      med_duty_cfg   = MedSpeedReset;
      skew_limit_cfg = DiffLimitReset;
   endfunction

   // The motor that has counted more revolutions is slowed to the low duty once
   // the signed count difference leaves the tolerated band.
   function automatic void rebalance_duties();
      int skew;
      int band;
      skew = $signed(left_revs - right_revs);
      band = int'(skew_limit_cfg);
      if (skew > band) begin
         duty_left  = low_duty_cfg;
         duty_right = med_duty_cfg;
      end else if (skew < -band) begin
         duty_left  = med_duty_cfg;
         duty_right = low_duty_cfg;
      end else begin
         duty_left  = med_duty_cfg;
         duty_right = med_duty_cfg;
      end
   endfunction

   // Pin order is {right_in_b, right_in_a, left_in_b, left_in_a}. Codes past
   // coast leave the bridge floating, the same as coast.
   function automatic bridge_type bridge_for(logic [DirWidth-1:0] dir);
      bridge_type pins;
      case (dir)
         DIR_FORWARD:     pins = 4'b1010;
         DIR_BACKWARD:    pins = 4'b0101;
         DIR_LEFT:        pins = 4'b0110;
         DIR_RIGHT:       pins = 4'b1001;
         DIR_SHORT_BRAKE: pins = 4'b1111;
         default:         pins = 4'b0000;
      endcase
      return pins;
   endfunction

   // Applies one command to the drive state and returns the pins it leaves.
   function automatic pin_state_type apply_command(logic [CmdWidth-1:0]   cmd,
                                                   logic [DirWidth-1:0]   dir,
                                                   logic [CountWidth-1:0] target);
      pin_state_type pins;
      case (cmd)
         CMD_TICK: begin
            if (pwm_phase == PwmTop) begin
               pwm_phase = '0;
            end
            if (!brake_latched) begin
               rebalance_duties();
            end
            enable_left  = (pwm_phase <= duty_left);
            enable_right = (pwm_phase <= duty_right);
            pwm_phase    = pwm_phase + 1'b1;
         end
         CMD_LEFT_PULSE: begin
            left_revs = left_revs + 1'b1;
         end
         CMD_RIGHT_PULSE: begin
            right_revs = right_revs + 1'b1;
         end
         CMD_SET_DIR: begin
            bridge_now    = bridge_for(dir);
            brake_latched = 1'b0;
         end
         CMD_START: begin
            left_revs  = '0;
            right_revs = '0;
            goal_revs  = target;
         end
         CMD_BRAKE: begin
            // Coast with both duties forced to zero; the enable pins keep their
            // levels until the next tick.
            bridge_now    = 4'b0000;
            duty_left     = '0;
            duty_right    = '0;
            brake_latched = 1'b1;
         end
         default: begin
            // Unknown commands only report the current pins.
         end
      endcase
      pins.left_pwm       = enable_left;
      pins.right_pwm      = enable_right;
      pins.left_in_a      = bridge_now[0];
      pins.left_in_b      = bridge_now[1];
      pins.right_in_a     = bridge_now[2];
      pins.right_in_b     = bridge_now[3];
      pins.target_reached = (left_revs >= goal_revs) || (right_revs >= goal_revs);
      return pins;
   endfunction

   function automatic void flag_error(string msg);
      error_count++;
      if (error_count <= MaxReported) begin
         $display("%0t: %s", $time, msg);
      end
   endfunction

   initial begin
      clock = 1'b0;
      forever #(ClockPeriod / 2) clock = ~clock;
   end

   // Hard stop in case the block stops accepting commands or returning results.
   initial begin
      while (cycle_count < CycleLimit) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("dual_motor_pwm_drive_unit_tb: errors");
      $finish;
   end

   // Result side. All sampling happens right after the rising edge, so the values
   // seen are the ones that were present at the edge. A transfer there is checked
   // against the oldest expected result. The ready for the next edge is then
   // decided: a pending hold request forces a long stall, otherwise ready drops
   // at random according to the current idle percentage.
   initial begin : result_monitor
      pin_state_type got;
      pin_state_type want;
      int unsigned   stall_left;
      stall_left = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && rsp_ready) begin
            got = {rsp_left_pwm, rsp_right_pwm, rsp_left_in_a, rsp_left_in_b,
                   rsp_right_in_a, rsp_right_in_b, rsp_target_reached};
            if (expected_pins.size() == 0) begin
               flag_error($sformatf("result with nothing expected: got %b", got));
            end else begin
               want = expected_pins.pop_front();
               if (got !== want) begin
                  flag_error($sformatf({"result mismatch (lpwm rpwm la lb ra rb reached): ",
                                        "expected %b got %b"}, want, got));
               end
            end
         end
         if (hold_request > 0) begin
            stall_left   = hold_request;
            hold_request = 0;
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(99) >= receiver_idle_pct);
         end
      end
   end

   // Offers one command and returns at the edge of its transfer. Valid is only
   // lowered when an idle gap is taken, so back-to-back commands keep it high.
   task automatic send_command(input logic [CmdWidth-1:0]   cmd,
                               input logic [DirWidth-1:0]   dir,
                               input logic [CountWidth-1:0] target);
      int unsigned gap;
      gap = 0;
      while (gap < 16 && $urandom_range(99) < sender_idle_pct) begin
         gap++;
      end
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_command     <= cmd;
      req_direction   <= dir;
      req_target_revs <= target;
      @(posedge clock);
      while (!req_ready) begin
         @(posedge clock);
      end
      expected_pins.push_back(apply_command(cmd, dir, target));
      items_sent++;
   endtask

   // Stops offering commands and waits until every expected result has come back,
   // then waits for the two-stage pipeline to go quiet.
   task automatic wait_for_results();
      req_valid <= 1'b0;
      while (expected_pins.size() != 0) begin
         @(posedge clock);
      end
      repeat (4) @(posedge clock);
   endtask

   // Writes all three registers on consecutive edges while the block is idle.
   // The upper byte of the write data for the 8-bit registers carries random junk that must be ignored.
   task automatic program_speeds(input logic [DutyWidth-1:0]  low,
                                 input logic [DutyWidth-1:0]  med,
                                 input logic [LimitWidth-1:0] limit);
      logic [7:0] junk_low;
      logic [7:0] junk_med;
      junk_low = 8'($urandom);
      junk_med = 8'($urandom);
      wait_for_results();
      csr_write_en <= 1'b1;
      csr_index    <= CSR_LOW_SPEED;
      csr_wdata    <= {junk_low, low};
      @(posedge clock);
      csr_index    <= CSR_MED_SPEED;
      csr_wdata    <= {junk_med, med};
      @(posedge clock);
      csr_index    <= CSR_DIFF_LIMIT;
      csr_wdata    <= limit;
      @(posedge clock);
      csr_write_en <= 1'b0;
      low_duty_cfg   = low;
      med_duty_cfg   = med;
      skew_limit_cfg = limit;
   endtask

   // Random traffic shaped like real driving: a start with a mostly reachable target
   // and a direction, then ticks and encoder pulses leaning to one side, mixed with
   // direction changes, brakes and unknown codes, pushing the balance logic out of
   // its band. A minority of bursts are unstructured, with every field random.
   task automatic run_drive_missions(input int unsigned item_budget);
      int unsigned         stop_at;
      int unsigned         length;
      int unsigned         lean;
      int unsigned         roll;
      logic [CmdWidth-1:0] odd_cmd;
      stop_at = items_sent + item_budget;
      while (items_sent < stop_at) begin
         if ($urandom_range(99) < 15) begin
            repeat ($urandom_range(3, 15)) begin
               send_command(CmdWidth'($urandom), DirWidth'($urandom), $urandom);
            end
         end else begin
            send_command(CMD_START, DirWidth'($urandom),
                         ($urandom_range(99) < 80) ? $urandom_range(0, 60) : $urandom);
            send_command(CMD_SET_DIR,
                         DirWidth'(($urandom_range(9) == 0) ? $urandom
                                                            : $urandom_range(0, 5)),
                         $urandom);
            length = $urandom_range(10, 90);
            lean   = $urandom_range(0, 100);
            repeat (length) begin
               roll = $urandom_range(99);
               if (roll < 50) begin
                  send_command(CMD_TICK, DirWidth'($urandom), $urandom);
               end else if (roll < 82) begin
                  send_command(($urandom_range(99) < lean) ? CMD_LEFT_PULSE : CMD_RIGHT_PULSE,
                               DirWidth'($urandom), $urandom);
               end else if (roll < 90) begin
                  send_command(CMD_SET_DIR, DirWidth'($urandom), $urandom);
               end else if (roll < 95) begin
                  send_command(CMD_BRAKE, DirWidth'($urandom), $urandom);
               end else begin
                  odd_cmd = CMD_BRAKE;
                  odd_cmd = CmdWidth'(odd_cmd + 1 + $urandom_range(1));
                  send_command(odd_cmd, DirWidth'($urandom), $urandom);
               end
            end
         end
      end
   endtask

   // Every command and direction code, the unknown codes, both target extremes,
   // and the brake hold followed by a tick and a release.
   task automatic test_directed();
      send_command(CMD_TICK, DIR_FORWARD, '0);
      for (int code = CMD_BRAKE + 1; code < (1 << CmdWidth); code++) begin
         send_command(code[CmdWidth-1:0], DirWidth'($urandom), $urandom);
      end
      for (int code = 0; code < (1 << DirWidth); code++) begin
         send_command(CMD_SET_DIR, code[DirWidth-1:0], $urandom);
      end
      send_command(CMD_LEFT_PULSE, DIR_FORWARD, '0);
      send_command(CMD_RIGHT_PULSE, DIR_FORWARD, '0);
      send_command(CMD_START, DIR_COAST, '1);
      send_command(CMD_LEFT_PULSE, DIR_FORWARD, '0);
      send_command(CMD_START, DIR_COAST, '0);
      send_command(CMD_TICK, DIR_FORWARD, '0);
      send_command(CMD_BRAKE, DIR_FORWARD, '0);
      send_command(CMD_TICK, DIR_FORWARD, '0);
      send_command(CMD_SET_DIR, DIR_FORWARD, '0);
      send_command(CMD_TICK, DIR_FORWARD, '0);
      send_command(CMD_START, DIR_FORWARD, 32'd1);
      send_command(CMD_LEFT_PULSE, DIR_FORWARD, '0);
   endtask

   // Low duty at zero, cruising duty at full scale and no tolerated difference,
   // so any skew between the encoders flips the duties.
   task automatic test_tight_balance();
      program_speeds(8'd0, 8'd255, 16'd0);
      run_drive_missions(550);
   endtask

   // The opposite corner: the widest band never corrects, and a cruising duty of
   // zero leaves the enables high only at counter zero.
   task automatic test_wide_band();
      program_speeds(8'd255, 8'd0, 16'hFFFF);
      run_drive_missions(550);
   endtask

   // A handful of ordinary settings with bands small enough to be crossed.
   task automatic test_random_settings();
      repeat (4) begin
         program_speeds(DutyWidth'($urandom), DutyWidth'($urandom),
                        LimitWidth'($urandom_range(0, 20)));
         run_drive_missions(180);
      end
   endtask

   // The receiver stalls for a long stretch while commands keep coming, which
   // fills the pipeline and must hold off the command side. Then the sender waits
   // for every result before going on.
   task automatic test_backpressure();
      hold_request = 80;
      run_drive_missions(60);
      wait_for_results();
      run_drive_missions(20);
   endtask

   initial begin
      reset_drive_state();
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      sender_idle_pct   = 37;
      receiver_idle_pct = 69;
      test_directed();
      test_tight_balance();

      sender_idle_pct   = 69;
      receiver_idle_pct = 37;
      test_wide_band();

      sender_idle_pct   = 0;
      receiver_idle_pct = 0;
      test_random_settings();
      test_backpressure();

      wait_for_results();
      repeat (6) @(posedge clock);
      if (error_count == 0) begin
         $display("dual_motor_pwm_drive_unit_tb: clean");
      end else begin
         $display("dual_motor_pwm_drive_unit_tb: errors");
      end
      $finish;
   end

endmodule

/* files.f */
hw/rtl/dmpd_pkg.sv
hw/rtl/dual_motor_pwm_drive_unit.sv
sim/dual_motor_pwm_drive_unit_tb.sv
